@@ src/oal_pkg.sv @@
// Shared types and constants of the ordered list engine.
// Depends on nothing; used by oal_ram, oal_ctrl and the top level.
package oal_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int VAL_W      = 32;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [AW-1:0]                addr_t;
  typedef logic [CW-1:0]                cnt_t;

  typedef enum logic [2:0] {
    REQ_APPEND   = 3'd0,
    REQ_INSERT   = 3'd1,
    REQ_REMOVE   = 3'd2,
    REQ_REMVAL   = 3'd3,
    REQ_REVERSE  = 3'd4,
    REQ_CONTAINS = 3'd5,
    REQ_CLEAR    = 3'd6,
    REQ_READ     = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    req_e                     op;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic                     found;
    logic signed [VAL_W-1:0]  read_data;
    logic [4:0]               entry_count;
    logic [4:0]               removed_count;
  } res_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

@@ src/oal_ram.sv @@
// Entry store of the ordered list engine: one write port, one registered read port.
// Depends on oal_pkg.
module oal_ram (
  input  logic              clk_i,
  input  oal_pkg::mem_req_t mem_i,
  output oal_pkg::data_t    rdata_o
);

  oal_pkg::data_t mem_q [oal_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rdata_o <= mem_q[mem_i.raddr];
    end
  end

endmodule

@@ src/oal_ctrl.sv @@
// Sequencer of the ordered list engine: walks the entry store one read a cycle,
// compares each entry and writes moved entries back. Depends on oal_pkg.
module oal_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  oal_pkg::req_t      req_i,
  output logic               req_ready_o,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output oal_pkg::res_t      res_o,
  output oal_pkg::mem_req_t  mem_o,
  input  oal_pkg::data_t     mem_rdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_RUN, S_FIN} state_e;

  state_e                       state_q;
  oal_pkg::req_e                op_q;
  oal_pkg::data_t               val_q;
  logic [oal_pkg::POS_W-1:0]    pos_q;
  oal_pkg::cnt_t                count_q;
  oal_pkg::cnt_t                rem_q;
  oal_pkg::cnt_t                j_q;
  oal_pkg::addr_t               lo_q;
  oal_pkg::addr_t               hi_q;
  logic                         tog_q;
  logic                         rv_q;
  oal_pkg::addr_t               ra_q;
  logic                         tg_q;
  oal_pkg::data_t               t_q;
  oal_pkg::addr_t               ta_q;
  oal_pkg::addr_t               pa_q;
  logic                         pend_q;
  logic                         ok_q;
  oal_pkg::status_e             status_q;
  logic                         found_q;
  oal_pkg::data_t               rdata_q;

  logic                         eq;
  logic                         finish;
  oal_pkg::cnt_t                count_d;
  oal_pkg::cnt_t                removed;

  assign eq          = (mem_rdata_i == val_q);
  assign req_ready_o = (state_q == S_IDLE);
  assign finish      = (state_q == S_FIN) && res_ready_i;
  assign res_valid_o = finish;

  always_comb begin
    count_d = count_q;
    removed = '0;
    unique case (op_q)
      oal_pkg::REQ_APPEND, oal_pkg::REQ_INSERT: begin
        if (ok_q) count_d = oal_pkg::cnt_t'(count_q + 1'b1);
      end
      oal_pkg::REQ_REMOVE: begin
        if (ok_q) begin
          count_d = oal_pkg::cnt_t'(count_q - 1'b1);
          removed = oal_pkg::cnt_t'(1);
        end
      end
      oal_pkg::REQ_REMVAL: begin
        count_d = j_q;
        removed = oal_pkg::cnt_t'(count_q - j_q);
      end
      oal_pkg::REQ_CLEAR: begin
        count_d = '0;
        removed = count_q;
      end
      oal_pkg::REQ_REVERSE, oal_pkg::REQ_CONTAINS, oal_pkg::REQ_READ: begin
        count_d = count_q;
      end
    endcase
  end

  always_comb begin
    res_o.status        = status_q;
    res_o.found         = found_q;
    res_o.read_data     = oal_pkg::VAL_W'(rdata_q);
    res_o.entry_count   = 5'(count_d);
    res_o.removed_count = 5'(removed);
  end

  always_comb begin
    mem_o.re    = (state_q == S_RUN) && (rem_q != '0);
    mem_o.raddr = lo_q;
    if (op_q == oal_pkg::REQ_INSERT) begin
      mem_o.raddr = hi_q;
    end else if (op_q == oal_pkg::REQ_REVERSE && tog_q) begin
      mem_o.raddr = hi_q;
    end
    mem_o.we    = 1'b0;
    mem_o.waddr = ra_q;
    mem_o.wdata = mem_rdata_i;
    if (state_q == S_RUN && rv_q) begin
      unique case (op_q)
        oal_pkg::REQ_INSERT: begin
          mem_o.we    = 1'b1;
          mem_o.waddr = oal_pkg::addr_t'(ra_q + 1'b1);
        end
        oal_pkg::REQ_REMOVE: begin
          mem_o.we    = 1'b1;
          mem_o.waddr = oal_pkg::addr_t'(ra_q - 1'b1);
        end
        oal_pkg::REQ_REMVAL: begin
          mem_o.we    = !eq;
          mem_o.waddr = j_q[oal_pkg::AW-1:0];
        end
        oal_pkg::REQ_REVERSE: begin
          if (tg_q) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = ta_q;
          end else begin
            mem_o.we    = pend_q;
            mem_o.waddr = pa_q;
            mem_o.wdata = t_q;
          end
        end
        oal_pkg::REQ_APPEND, oal_pkg::REQ_CONTAINS, oal_pkg::REQ_CLEAR,
        oal_pkg::REQ_READ: begin
          mem_o.we = 1'b0;
        end
      endcase
    end else if (finish) begin
      unique case (op_q)
        oal_pkg::REQ_APPEND: begin
          mem_o.we    = ok_q;
          mem_o.waddr = count_q[oal_pkg::AW-1:0];
          mem_o.wdata = val_q;
        end
        oal_pkg::REQ_INSERT: begin
          mem_o.we    = ok_q;
          mem_o.waddr = pos_q[oal_pkg::AW-1:0];
          mem_o.wdata = val_q;
        end
        oal_pkg::REQ_REVERSE: begin
          mem_o.we    = pend_q;
          mem_o.waddr = pa_q;
          mem_o.wdata = t_q;
        end
        oal_pkg::REQ_REMOVE, oal_pkg::REQ_REMVAL, oal_pkg::REQ_CONTAINS,
        oal_pkg::REQ_CLEAR, oal_pkg::REQ_READ: begin
          mem_o.we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= oal_pkg::REQ_APPEND;
      val_q    <= '0;
      pos_q    <= '0;
      count_q  <= '0;
      rem_q    <= '0;
      j_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      tog_q    <= 1'b0;
      rv_q     <= 1'b0;
      ra_q     <= '0;
      tg_q     <= 1'b0;
      t_q      <= '0;
      ta_q     <= '0;
      pa_q     <= '0;
      pend_q   <= 1'b0;
      ok_q     <= 1'b0;
      status_q <= oal_pkg::STAT_DONE;
      found_q  <= 1'b0;
      rdata_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            op_q    <= req_i.op;
            val_q   <= oal_pkg::DATA_WIDTH'(req_i.value);
            pos_q   <= req_i.position;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          ok_q     <= 1'b1;
          status_q <= oal_pkg::STAT_DONE;
          found_q  <= 1'b0;
          rdata_q  <= '0;
          rem_q    <= '0;
          j_q      <= '0;
          lo_q     <= '0;
          hi_q     <= oal_pkg::addr_t'(count_q - 1'b1);
          tog_q    <= 1'b0;
          pend_q   <= 1'b0;
          rv_q     <= 1'b0;
          unique case (op_q)
            oal_pkg::REQ_APPEND: begin
              if (count_q >= oal_pkg::cnt_t'(oal_pkg::DEPTH)) begin
                ok_q     <= 1'b0;
                status_q <= oal_pkg::STAT_FULL;
              end
            end
            oal_pkg::REQ_INSERT: begin
              if (oal_pkg::CW'(pos_q) > count_q) begin
                ok_q     <= 1'b0;
                status_q <= oal_pkg::STAT_RANGE;
              end else if (count_q >= oal_pkg::cnt_t'(oal_pkg::DEPTH)) begin
                ok_q     <= 1'b0;
                status_q <= oal_pkg::STAT_FULL;
              end else begin
                rem_q <= oal_pkg::cnt_t'(count_q - oal_pkg::CW'(pos_q));
              end
            end
            oal_pkg::REQ_REMOVE: begin
              if (oal_pkg::CW'(pos_q) >= count_q) begin
                ok_q     <= 1'b0;
                status_q <= oal_pkg::STAT_RANGE;
              end else begin
                rem_q <= oal_pkg::cnt_t'(count_q - oal_pkg::CW'(pos_q) - 1'b1);
                lo_q  <= oal_pkg::addr_t'(pos_q + 1'b1);
              end
            end
            oal_pkg::REQ_REMVAL, oal_pkg::REQ_CONTAINS: begin
              rem_q <= count_q;
            end
            oal_pkg::REQ_REVERSE: begin
              rem_q <= {count_q[oal_pkg::CW-1:1], 1'b0};
            end
            oal_pkg::REQ_CLEAR: begin
              rem_q <= '0;
            end
            oal_pkg::REQ_READ: begin
              if (oal_pkg::CW'(pos_q) >= count_q) begin
                ok_q     <= 1'b0;
                status_q <= oal_pkg::STAT_RANGE;
              end else begin
                rem_q <= oal_pkg::cnt_t'(1);
                lo_q  <= pos_q[oal_pkg::AW-1:0];
              end
            end
          endcase
          state_q <= S_RUN;
        end
        S_RUN: begin
          rv_q <= mem_o.re;
          ra_q <= mem_o.raddr;
          tg_q <= tog_q;
          if (mem_o.re) begin
            rem_q <= oal_pkg::cnt_t'(rem_q - 1'b1);
            if (op_q == oal_pkg::REQ_INSERT) begin
              hi_q <= oal_pkg::addr_t'(hi_q - 1'b1);
            end else if (op_q == oal_pkg::REQ_REVERSE) begin
              tog_q <= !tog_q;
              if (tog_q) hi_q <= oal_pkg::addr_t'(hi_q - 1'b1);
              else       lo_q <= oal_pkg::addr_t'(lo_q + 1'b1);
            end else begin
              lo_q <= oal_pkg::addr_t'(lo_q + 1'b1);
            end
          end
          if (rv_q) begin
            unique case (op_q)
              oal_pkg::REQ_REMVAL: begin
                if (!eq) j_q <= oal_pkg::cnt_t'(j_q + 1'b1);
              end
              oal_pkg::REQ_CONTAINS: begin
                if (eq) found_q <= 1'b1;
              end
              oal_pkg::REQ_READ: begin
                rdata_q <= mem_rdata_i;
              end
              oal_pkg::REQ_REVERSE: begin
                if (tg_q) begin
                  pend_q <= 1'b1;
                  pa_q   <= ra_q;
                end else begin
                  t_q    <= mem_rdata_i;
                  ta_q   <= ra_q;
                  pend_q <= 1'b0;
                end
              end
              oal_pkg::REQ_APPEND, oal_pkg::REQ_INSERT, oal_pkg::REQ_REMOVE,
              oal_pkg::REQ_CLEAR: begin
                rdata_q <= rdata_q;
              end
            endcase
          end
          if (rem_q == '0 && !rv_q) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready_i) begin
            count_q <= count_d;
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ src/ordered_array_list_engine_top.sv @@
// Ordered list engine: holds up to DEPTH signed entries and applies list requests.
// Instantiates oal_ctrl (sequencer) and oal_ram (entry store); depends on oal_pkg.
//
// Usage:
//   Input beats arrive on the s_axis group: tuser carries the request kind,
//   tdata the value and the position. Each request yields one result beat on
//   the m_axis group with status, found flag, read data, entry count and the
//   number of entries removed.
//   The block takes one request at a time; s_axis_tready is low while it works.
//   The sequencer walks entries one at a time through the single read port
//   of the entry store for insert, remove, remove-by-value, reverse and
//   contains, and reads a single entry for a read; append, clear and
//   out-of-range requests walk no entry.
//   The sequencer passes through its idle state between two requests.
//   The result beat sits in an output register; the next request is taken and
//   worked on while it waits, and the sequencer holds its last step until the
//   register is free, so a stalled receiver loses nothing.
//   Reset empties the list (count zero) and clears the output valid flag; entry
//   contents stay as they were and are never read before being written.
module ordered_array_list_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], position[36:32], zero fill
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], found[2], read_data[34:3],
                                     // entry_count[39:35], removed_count[44:40]
);

  oal_pkg::req_t     req;
  oal_pkg::res_t     res;
  logic              res_valid;
  logic              res_ready;
  oal_pkg::mem_req_t mem_req;
  oal_pkg::data_t    mem_rdata;
  logic              out_valid_q;
  logic [47:0]       out_data_q;

  assign req.op       = oal_pkg::req_e'(s_axis_tuser);
  assign req.value    = s_axis_tdata[31:0];
  assign req.position = s_axis_tdata[36:32];

  assign res_ready = !out_valid_q || m_axis_tready;

  oal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  oal_ram u_ram (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= {3'b000, res.removed_count, res.entry_count, res.read_data,
                     res.found, res.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for ordered_array_list_engine_top: a queue-fed driver and a monitor that
// checks every result beat against a behavioral list predictor. Depends on oal_pkg.
module tb;

  typedef struct {
    oal_pkg::req_e op;
    logic [31:0]   value;
    logic [4:0]    pos;
  } list_req_t;

  typedef struct {
    oal_pkg::status_e status;
    logic             found;
    logic [31:0]      read_data;
    logic [4:0]       entry_count;
    logic [4:0]       removed_count;
  } list_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  ordered_array_list_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  list_req_t   request_backlog[$];
  list_res_t   expected_results[$];
  list_req_t   cur_req;
  list_res_t   want_res;
  list_res_t   pred_res;
  logic        beat_taken = 1'b0;
  int          issued = 0;
  int          accepted = 0;
  int          results_seen = 0;
  int          errors = 0;

  // list contents as the block should hold them
  logic [31:0] slots [oal_pkg::DEPTH];
  int          used = 0;

  function automatic list_res_t apply_request(list_req_t rq);
    list_res_t   r;
    int          k;
    int          keep;
    logic [31:0] tmp;
    r.status        = oal_pkg::STAT_DONE;
    r.found         = 1'b0;
    r.read_data     = '0;
    r.removed_count = '0;
    case (rq.op)
      oal_pkg::REQ_APPEND: begin
        if (used >= oal_pkg::DEPTH) begin
          r.status = oal_pkg::STAT_FULL;
        end else begin
          slots[used] = rq.value;
          used++;
        end
      end
      oal_pkg::REQ_INSERT: begin
        if (int'(rq.pos) > used) begin
          r.status = oal_pkg::STAT_RANGE;
        end else if (used >= oal_pkg::DEPTH) begin
          r.status = oal_pkg::STAT_FULL;
        end else begin
          for (k = used; k > int'(rq.pos); k--) slots[k] = slots[k-1];
          slots[rq.pos] = rq.value;
          used++;
        end
      end
      oal_pkg::REQ_REMOVE: begin
        if (int'(rq.pos) >= used) begin
          r.status = oal_pkg::STAT_RANGE;
        end else begin
          for (k = int'(rq.pos); k < used - 1; k++) slots[k] = slots[k+1];
          used--;
          r.removed_count = 5'd1;
        end
      end
      oal_pkg::REQ_REMVAL: begin
        keep = 0;
        for (k = 0; k < used; k++) begin
          if (slots[k] != rq.value) begin
            slots[keep] = slots[k];
            keep++;
          end
        end
        r.removed_count = 5'(used - keep);
        used = keep;
      end
      oal_pkg::REQ_REVERSE: begin
        for (k = 0; k < used / 2; k++) begin
          tmp               = slots[k];
          slots[k]          = slots[used-1-k];
          slots[used-1-k]   = tmp;
        end
      end
      oal_pkg::REQ_CONTAINS: begin
        for (k = 0; k < used; k++) if (slots[k] == rq.value) r.found = 1'b1;
      end
      oal_pkg::REQ_CLEAR: begin
        r.removed_count = 5'(used);
        used = 0;
      end
      oal_pkg::REQ_READ: begin
        if (int'(rq.pos) >= used) r.status = oal_pkg::STAT_RANGE;
        else r.read_data = slots[rq.pos];
      end
      default: ;
    endcase
    r.entry_count = 5'(used);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // take the beat, then present the next request or idle
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pred_res = apply_request(cur_req);
      expected_results = {expected_results, pred_res};
      accepted++;
      beat_taken = 1'b1;
    end else begin
      beat_taken = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || beat_taken) begin
        if (request_backlog.size() > 0 &&
            ((accepted >= 150 && accepted < 230) || $urandom_range(99) >= 20)) begin
          cur_req = request_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cur_req.pos, cur_req.value};
          s_axis_tuser  <= cur_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= (results_seen >= 260 && results_seen < 340) ||
                       ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding: %0h", m_axis_tdata);
        errors++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("status", 32'(want_res.status), 32'(m_axis_tdata[1:0]));
        check_field("found", 32'(want_res.found), 32'(m_axis_tdata[2]));
        check_field("read_data", want_res.read_data, m_axis_tdata[34:3]);
        check_field("entry_count", 32'(want_res.entry_count), 32'(m_axis_tdata[39:35]));
        check_field("removed_count", 32'(want_res.removed_count),
                    32'(m_axis_tdata[44:40]));
      end
    end
  end

  task automatic queue_req(oal_pkg::req_e op, logic [31:0] v, int p);
    list_req_t rq;
    rq.op    = op;
    rq.value = v;
    rq.pos   = 5'(p);
    request_backlog = {request_backlog, rq};
    issued++;
  endtask

  task automatic wait_drain();
    while (results_seen != issued) @(posedge clk_i);
  endtask

  logic [31:0] value_pool [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                  32'hffff_ffff, 32'h0000_0001, 32'h5a5a_a5a5};
  // cumulative weights per op: grow, shrink, mixed; the remainder is read
  int op_weights [3][7] = '{'{35, 65, 70, 73, 78, 85, 86},
                            '{10, 15, 45, 65, 70, 80, 84},
                            '{20, 35, 47, 55, 62, 72, 75}};

  initial begin
    int          i;
    int          j;
    int          kind;
    int          len;
    int          roll;
    int          idx;
    logic        paused;
    logic [31:0] v;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list corners
    queue_req(oal_pkg::REQ_READ, 32'h0, 0);
    queue_req(oal_pkg::REQ_REMOVE, 32'h0, 0);
    queue_req(oal_pkg::REQ_REVERSE, 32'h0, 3);
    queue_req(oal_pkg::REQ_CONTAINS, 32'h0, 0);
    queue_req(oal_pkg::REQ_CLEAR, 32'h0, 0);
    queue_req(oal_pkg::REQ_REMVAL, 32'h0, 0);
    // value extremes, inserts at head, end and past the end
    queue_req(oal_pkg::REQ_APPEND, 32'h8000_0000, 0);
    queue_req(oal_pkg::REQ_APPEND, 32'h7fff_ffff, 31);
    queue_req(oal_pkg::REQ_APPEND, 32'h0, 0);
    queue_req(oal_pkg::REQ_APPEND, 32'hffff_ffff, 16);
    queue_req(oal_pkg::REQ_INSERT, 32'h5555_aaaa, 0);
    queue_req(oal_pkg::REQ_INSERT, 32'h1234_5678, 7);
    queue_req(oal_pkg::REQ_INSERT, 32'hffff_ffff, 5);
    queue_req(oal_pkg::REQ_READ, 32'h0, 0);
    queue_req(oal_pkg::REQ_READ, 32'h0, 16);
    queue_req(oal_pkg::REQ_CONTAINS, 32'h7fff_ffff, 0);
    queue_req(oal_pkg::REQ_CONTAINS, 32'h0000_1234, 0);
    queue_req(oal_pkg::REQ_REMVAL, 32'hffff_ffff, 0);
    queue_req(oal_pkg::REQ_REMVAL, 32'h0000_002a, 0);
    queue_req(oal_pkg::REQ_REMOVE, 32'h0, 0);
    queue_req(oal_pkg::REQ_REMOVE, 32'h0, 16);
    queue_req(oal_pkg::REQ_REVERSE, 32'h0, 0);
    queue_req(oal_pkg::REQ_READ, 32'h0, 2);
    // fill to the top, then hit the full list
    for (i = 0; i < oal_pkg::DEPTH - 3; i++) queue_req(oal_pkg::REQ_APPEND, $urandom(), 0);
    queue_req(oal_pkg::REQ_APPEND, 32'h0bad_0bad, 0);
    queue_req(oal_pkg::REQ_INSERT, 32'h0bad_0bad, 16);
    queue_req(oal_pkg::REQ_INSERT, 32'h0bad_0bad, 0);
    queue_req(oal_pkg::REQ_READ, 32'h0, 15);
    queue_req(oal_pkg::REQ_REVERSE, 32'h0, 0);
    queue_req(oal_pkg::REQ_CLEAR, 32'h0, 0);
    wait_drain();

    i = 0;
    while (i < 350) begin
      kind = $urandom_range(2);
      len  = $urandom_range(30, 10);
      for (j = 0; j < len; j++) begin
        roll = $urandom_range(99);
        idx  = 7;
        for (int t = 6; t >= 0; t--) if (roll < op_weights[kind][t]) idx = t;
        v = $urandom_range(1) ? value_pool[$urandom_range(5)] : $urandom();
        queue_req(oal_pkg::req_e'(idx), v, $urandom_range(16));
        i++;
      end
      if (!paused && i >= 200) begin
        paused = 1'b1;
        wait_drain();
      end
    end

    wait_drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ordered_array_list_engine_top] OK");
    end else begin
      $display("[ordered_array_list_engine_top] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[ordered_array_list_engine_top] ERROR");
    $finish;
  end

endmodule
